// ===== design/assert_macros.svh =====
// assertion helper macros for the sonar point converter
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define SPTC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// plain invariant checked on every clock edge outside reset
`define SPTC_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error(msg);

`endif

// ===== design/sptc_pkg.sv =====
// shared types, constants and the trig evaluation function
// used by all modules of the sonar polar to cartesian converter
package sptc_pkg;

    localparam int NUM_W = 28;
    localparam int DIV_W = 11;

    localparam longint TWO_PI_Q28 = 64'sd1686629713;
    localparam longint PI_Q28 = TWO_PI_Q28 / 2;
    localparam longint HALF_PI_Q28 = TWO_PI_Q28 / 4;

    localparam int FULL_TURN_Q8 = 92160;
    localparam int HALF_TURN_Q8 = FULL_TURN_Q8 / 2;
    localparam int ANGLE_OFFSET = 1460 * FULL_TURN_Q8;
    localparam int COORD_LIMIT = 256000;

    localparam int RECIP45_A = (1 << 23) / 45;
    localparam int RECIP45_B = (1 << 26) / 45;

    typedef enum logic [2:0] {
        REG_MIN_RANGE  = 3'd0,
        REG_MAX_RANGE  = 3'd1,
        REG_FAN_WIDTH  = 3'd2,
        REG_THRESHOLD  = 3'd3,
        REG_RANGE_BINS = 3'd4,
        REG_AZ_BINS    = 3'd5
    } reg_addr_t;

    typedef struct packed {
        logic pt;
        logic fend;
        logic neg;
    } sb_t;

    // q1.15 sine of a q28 radian phase in [0, 2pi)
    function automatic longint sine_q15(input longint x);
        longint xx;
        longint x2;
        longint term;
        longint sum;
        logic   neg;
        neg = 1'b0;
        xx = x;
        if (xx >= PI_Q28) begin
            xx = xx - PI_Q28;
            neg = 1'b1;
        end
        if (xx > HALF_PI_Q28) xx = PI_Q28 - xx;
        if (xx < 0) xx = 0;
        x2 = (xx * xx) >>> 28;
        term = xx;
        sum = xx;
        term = ((term * x2) >>> 28) / 6;
        sum = sum - term;
        term = ((term * x2) >>> 28) / 20;
        sum = sum + term;
        term = ((term * x2) >>> 28) / 42;
        sum = sum - term;
        term = ((term * x2) >>> 28) / 72;
        sum = sum + term;
        term = ((term * x2) >>> 28) / 110;
        sum = sum - term;
        if (sum < 0) sum = 0;
        sum = (sum + 4096) >>> 13;
        if (sum > 32767) sum = 32767;
        return neg ? -sum : sum;
    endfunction

endpackage

// ===== design/sptc_div_pipe.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage
// depends on sptc_pkg
module sptc_div_pipe (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  sptc_pkg::sb_t                in_sb,
    input  logic [sptc_pkg::NUM_W-1:0]   in_num_d,
    input  logic [sptc_pkg::NUM_W-1:0]   in_num_a,
    input  logic [sptc_pkg::DIV_W-1:0]   div_d,
    input  logic [sptc_pkg::DIV_W-1:0]   div_a,
    output logic                         out_valid,
    output sptc_pkg::sb_t                out_sb,
    output logic [sptc_pkg::NUM_W-1:0]   out_q_d,
    output logic                         out_rem_nz_d,
    output logic [sptc_pkg::NUM_W-1:0]   out_q_a
);
    localparam int N = sptc_pkg::NUM_W;
    localparam int W = sptc_pkg::DIV_W;

    logic          vld_reg [N];
    sptc_pkg::sb_t sb_reg  [N];
    logic [N-1:0]  nd_reg  [N];
    logic [N-1:0]  na_reg  [N];
    logic [W-1:0]  rd_reg  [N];
    logic [W-1:0]  ra_reg  [N];

    function automatic logic [W+N-1:0] div_step(input logic [W-1:0] rem,
                                                input logic [N-1:0] num,
                                                input logic [W-1:0] dv);
        logic [W:0] sh;
        logic [W:0] sub;
        sh = {rem, num[N-1]};
        sub = sh - {1'b0, dv};
        if (sh >= {1'b0, dv}) begin
            return {sub[W-1:0], num[N-2:0], 1'b1};
        end
        return {sh[W-1:0], num[N-2:0], 1'b0};
    endfunction

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic          v_in;
        sptc_pkg::sb_t sb_in;
        logic [N-1:0]  nd_in;
        logic [N-1:0]  na_in;
        logic [W-1:0]  rd_in;
        logic [W-1:0]  ra_in;
        logic [W+N-1:0] sd;
        logic [W+N-1:0] sa;

        if (g == 0) begin : g_first
            assign v_in  = in_valid;
            assign sb_in = in_sb;
            assign nd_in = in_num_d;
            assign na_in = in_num_a;
            assign rd_in = '0;
            assign ra_in = '0;
        end else begin : g_rest
            assign v_in  = vld_reg[g-1];
            assign sb_in = sb_reg[g-1];
            assign nd_in = nd_reg[g-1];
            assign na_in = na_reg[g-1];
            assign rd_in = rd_reg[g-1];
            assign ra_in = ra_reg[g-1];
        end

        assign sd = div_step(rd_in, nd_in, div_d);
        assign sa = div_step(ra_in, na_in, div_a);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sb_reg[g] <= sb_in;
                rd_reg[g] <= sd[W+N-1:N];
                nd_reg[g] <= sd[N-1:0];
                ra_reg[g] <= sa[W+N-1:N];
                na_reg[g] <= sa[N-1:0];
            end
        end
    end

    assign out_valid    = vld_reg[N-1];
    assign out_sb       = sb_reg[N-1];
    assign out_q_d      = nd_reg[N-1];
    assign out_rem_nz_d = (rd_reg[N-1] != '0);
    assign out_q_a      = na_reg[N-1];

endmodule

// ===== design/sptc_angle_index.sv =====
// angle to trig table index: wrap modulo one turn and scale, five stages
// depends on sptc_pkg
module sptc_angle_index #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [27:0]                   u,
    output logic [$clog2(TABLE_SIZE)-1:0] k
);
    localparam int KW = $clog2(TABLE_SIZE);
    localparam int KQ_W = $clog2(TABLE_SIZE + 1);

    logic [34:0] p1_reg;
    logic [16:0] uhi_reg;
    logic [10:0] ulo_reg;
    logic [16:0] w_reg;
    logic [30:0] t_reg;
    logic [40:0] p2_reg;
    logic [19:0] thi_reg;
    logic [KW-1:0] k_reg;

    logic [11:0]   q1;
    logic [16:0]   r1;
    logic [16:0]   r1_fix;
    logic [16:0]   w_next;
    logic [KQ_W-1:0] q2;
    logic [19:0]   r2;
    logic [KQ_W-1:0] kk;
    logic [KW-1:0] k_next;

    always_comb begin
        q1 = p1_reg[34:23];
        r1 = uhi_reg - 17'(q1 * 6'd45);
        r1_fix = (r1 >= 17'd45) ? r1 - 17'd45 : r1;
        w_next = {r1_fix[5:0], ulo_reg};
        q2 = p2_reg[26 +: KQ_W];
        r2 = thi_reg - 20'(q2 * 6'd45);
        kk = (r2 >= 20'd45) ? q2 + KQ_W'(1) : q2;
        k_next = (32'(kk) == TABLE_SIZE) ? '0 : kk[KW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= 35'(u[27:11]) * 35'(sptc_pkg::RECIP45_A);
            uhi_reg <= u[27:11];
            ulo_reg <= u[10:0];
            w_reg   <= w_next;
            t_reg   <= 31'(w_reg) * 31'(TABLE_SIZE) + 31'(sptc_pkg::HALF_TURN_Q8);
            p2_reg  <= 41'(t_reg[30:11]) * 41'(sptc_pkg::RECIP45_B);
            thi_reg <= t_reg[30:11];
            k_reg   <= k_next;
        end
    end

    assign k = k_reg;

endmodule

// ===== design/sptc_trig_rom.sv =====
// constant q1.15 sine or cosine table with registered read
// depends on sptc_pkg for the series evaluation
module sptc_trig_rom #(
    parameter int DEPTH  = 1024,
    parameter bit COSINE = 1'b0
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output logic signed [15:0]       data
);
    typedef logic signed [15:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t   t;
        longint ph;
        for (int i = 0; i < DEPTH; i++) begin
            ph = (longint'(i) * sptc_pkg::TWO_PI_Q28) / DEPTH;
            if (COSINE) begin
                ph = ph + sptc_pkg::HALF_PI_Q28;
                if (ph >= sptc_pkg::TWO_PI_Q28) ph = ph - sptc_pkg::TWO_PI_Q28;
            end
            t[i] = 16'(sptc_pkg::sine_q15(ph));
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic signed [15:0] data_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

// ===== design/sonar_polar_to_cartesian_points.sv =====
// sonar bin to cartesian point converter, top level with apb registers
// depends on sptc_pkg, sptc_div_pipe, sptc_angle_index, sptc_trig_rom
// Takes one sonar bin per cycle while not stalled and gives one point word per bin
// through one input stage, 28 divider stages (one quotient bit each for distance and
// angle), the distance and angle stage, five stages of angle wrap and table indexing,
// the table read, the multiply and the rounding/saturation stage. The whole pipeline
// advances together and holds while the output word waits; s_ready is high whenever
// the output register is empty or being taken. Registers must be written only while
// no word is in flight; the block itself does not enforce this.
module sonar_polar_to_cartesian_points #(
    parameter int MAX_RANGE_BINS   = 1024,
    parameter int MAX_AZIMUTH_BINS = 1024,
    parameter int SINE_TABLE_SIZE  = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_intensity,
    input  logic [9:0]         s_range_bin,
    input  logic [9:0]         s_azimuth_bin,
    input  logic               s_frame_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_point_valid,
    output logic signed [18:0] m_point_x,
    output logic signed [18:0] m_point_y,
    output logic               m_frame_last
);
    `include "assert_macros.svh"

    localparam int KW = $clog2(SINE_TABLE_SIZE);
    localparam int NW = sptc_pkg::NUM_W;
    localparam int DW = sptc_pkg::DIV_W;

    logic [9:0]  min_range_reg;
    logic [9:0]  max_range_reg;
    logic [8:0]  fan_width_reg;
    logic [15:0] threshold_reg;
    logic [10:0] range_bins_reg;
    logic [10:0] az_bins_reg;

    logic en;
    logic wr_en;
    sptc_pkg::reg_addr_t wr_addr;

    logic [DW-1:0] rb;
    logic [DW-1:0] ab;

    logic                va_reg;
    sptc_pkg::sb_t       sba_reg;
    logic signed [21:0]  prod_d_reg;
    logic [18:0]         prod_a_reg;

    logic signed [10:0]  diff;
    logic signed [21:0]  prod_d_next;
    logic                neg_d;
    logic [19:0]         mag_d;
    sptc_pkg::sb_t       sba_next;
    sptc_pkg::sb_t       sb_div_in;

    logic          dv_valid;
    sptc_pkg::sb_t dv_sb;
    logic [NW-1:0] dv_q_d;
    logic          dv_rem_nz;
    logic [NW-1:0] dv_q_a;

    logic [8:0]          v_pipe_reg;
    sptc_pkg::sb_t       sb_pipe_reg [9];
    logic signed [29:0]  d_pipe_reg  [7];
    logic [27:0]         u_reg;

    logic signed [29:0]  dq;
    logic signed [29:0]  d_next;
    logic [28:0]         u_next;

    logic [KW-1:0]       k_g;
    logic signed [15:0]  sin_h;
    logic signed [15:0]  cos_h;

    logic signed [45:0]  px_reg;
    logic signed [45:0]  py_reg;
    logic signed [46:0]  px_rnd;
    logic signed [46:0]  py_rnd;
    logic signed [31:0]  xf;
    logic signed [31:0]  yf;
    logic signed [18:0]  x_next;
    logic signed [18:0]  y_next;
    logic signed [18:0]  x_reg;
    logic signed [18:0]  y_reg;

    // register port
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign wr_addr = sptc_pkg::reg_addr_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_range_reg  <= 10'd0;
            max_range_reg  <= 10'd100;
            fan_width_reg  <= 9'd120;
            threshold_reg  <= 16'd32768;
            range_bins_reg <= 11'd512;
            az_bins_reg    <= 11'd256;
        end else if (wr_en) begin
            case (wr_addr)
                sptc_pkg::REG_MIN_RANGE:  min_range_reg  <= pwdata[9:0];
                sptc_pkg::REG_MAX_RANGE:  max_range_reg  <= pwdata[9:0];
                sptc_pkg::REG_FAN_WIDTH:  fan_width_reg  <= pwdata[8:0];
                sptc_pkg::REG_THRESHOLD:  threshold_reg  <= pwdata[15:0];
                sptc_pkg::REG_RANGE_BINS: range_bins_reg <= pwdata[10:0];
                sptc_pkg::REG_AZ_BINS:    az_bins_reg    <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wr_addr)
            sptc_pkg::REG_MIN_RANGE:  prdata = 32'(min_range_reg);
            sptc_pkg::REG_MAX_RANGE:  prdata = 32'(max_range_reg);
            sptc_pkg::REG_FAN_WIDTH:  prdata = 32'(fan_width_reg);
            sptc_pkg::REG_THRESHOLD:  prdata = 32'(threshold_reg);
            sptc_pkg::REG_RANGE_BINS: prdata = 32'(range_bins_reg);
            sptc_pkg::REG_AZ_BINS:    prdata = 32'(az_bins_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    // clamped bin counts
    always_comb begin
        if (range_bins_reg == '0) begin
            rb = DW'(1);
        end else if (32'(range_bins_reg) > MAX_RANGE_BINS) begin
            rb = DW'(MAX_RANGE_BINS);
        end else begin
            rb = range_bins_reg;
        end
        if (az_bins_reg == '0) begin
            ab = DW'(1);
        end else if (32'(az_bins_reg) > MAX_AZIMUTH_BINS) begin
            ab = DW'(MAX_AZIMUTH_BINS);
        end else begin
            ab = az_bins_reg;
        end
    end

    assign en      = !v_pipe_reg[8] || m_ready;
    assign s_ready = en;

    // input stage: threshold and products
    always_comb begin
        diff = $signed({1'b0, max_range_reg}) - $signed({1'b0, min_range_reg});
        prod_d_next = $signed({1'b0, s_range_bin}) * diff;
        sba_next.pt = (s_intensity >= threshold_reg);
        sba_next.fend = s_frame_end;
        sba_next.neg = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sba_reg    <= sba_next;
            prod_d_reg <= prod_d_next;
            prod_a_reg <= 19'(fan_width_reg) * 19'(s_azimuth_bin);
        end
    end

    always_comb begin
        neg_d = prod_d_reg[21];
        mag_d = neg_d ? 20'(-prod_d_reg) : prod_d_reg[19:0];
        sb_div_in = sba_reg;
        sb_div_in.neg = neg_d;
    end

    sptc_div_pipe u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (va_reg),
        .in_sb        (sb_div_in),
        .in_num_d     ({mag_d, 8'd0}),
        .in_num_a     ({1'b0, prod_a_reg, 8'd0}),
        .div_d        (rb),
        .div_a        (ab),
        .out_valid    (dv_valid),
        .out_sb       (dv_sb),
        .out_q_d      (dv_q_d),
        .out_rem_nz_d (dv_rem_nz),
        .out_q_a      (dv_q_a)
    );

    // distance and shifted angle
    always_comb begin
        if (dv_sb.neg) begin
            dq = -$signed({2'b00, dv_q_d}) - $signed(30'(dv_rem_nz));
        end else begin
            dq = $signed({2'b00, dv_q_d});
        end
        d_next = $signed({12'd0, min_range_reg, 8'd0}) + dq;
        u_next = 29'({fan_width_reg[8:1], 8'd0}) + 29'(sptc_pkg::ANGLE_OFFSET)
                 - {1'b0, dv_q_a};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_pipe_reg <= '0;
        end else if (en) begin
            v_pipe_reg <= {v_pipe_reg[7:0], dv_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_pipe_reg[0] <= dv_sb;
            for (int i = 1; i < 9; i++) begin
                sb_pipe_reg[i] <= sb_pipe_reg[i-1];
            end
            d_pipe_reg[0] <= d_next;
            for (int i = 1; i < 7; i++) begin
                d_pipe_reg[i] <= d_pipe_reg[i-1];
            end
            u_reg <= u_next[27:0];
        end
    end

    sptc_angle_index #(
        .TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_angle (
        .aclk (aclk),
        .en   (en),
        .u    (u_reg),
        .k    (k_g)
    );

    sptc_trig_rom #(
        .DEPTH  (SINE_TABLE_SIZE),
        .COSINE (1'b0)
    ) u_sin_rom (
        .aclk (aclk),
        .en   (en),
        .addr (k_g),
        .data (sin_h)
    );

    sptc_trig_rom #(
        .DEPTH  (SINE_TABLE_SIZE),
        .COSINE (1'b1)
    ) u_cos_rom (
        .aclk (aclk),
        .en   (en),
        .addr (k_g),
        .data (cos_h)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= d_pipe_reg[6] * cos_h;
            py_reg <= d_pipe_reg[6] * sin_h;
        end
    end

    // round, flip y, saturate, zero dropped bins
    always_comb begin
        px_rnd = 47'(px_reg) + 47'sd16384;
        py_rnd = 47'(py_reg) + 47'sd16384;
        xf = px_rnd[46:15];
        yf = -py_rnd[46:15];
        if (xf > 32'sd256000) begin
            x_next = 19'sd256000;
        end else if (xf < -32'sd256000) begin
            x_next = -19'sd256000;
        end else begin
            x_next = xf[18:0];
        end
        if (yf > 32'sd256000) begin
            y_next = 19'sd256000;
        end else if (yf < -32'sd256000) begin
            y_next = -19'sd256000;
        end else begin
            y_next = yf[18:0];
        end
        if (!sb_pipe_reg[7].pt) begin
            x_next = '0;
            y_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign m_valid       = v_pipe_reg[8];
    assign m_point_valid = sb_pipe_reg[8].pt;
    assign m_frame_last  = sb_pipe_reg[8].fend;
    assign m_point_x     = x_reg;
    assign m_point_y     = y_reg;

    `SPTC_ASSERT_IMP(a_drop_zero, aclk, aresetn, m_valid && !m_point_valid,
        m_point_x == 19'sd0 && m_point_y == 19'sd0, "dropped bin carries coordinates")
    `SPTC_ASSERT_IMP(a_x_limit, aclk, aresetn, m_valid,
        m_point_x <= 19'sd256000 && m_point_x >= -19'sd256000, "x outside limit")
    `SPTC_ASSERT_IMP(a_y_limit, aclk, aresetn, m_valid,
        m_point_y <= 19'sd256000 && m_point_y >= -19'sd256000, "y outside limit")
    `SPTC_ASSERT_IMP(a_index_range, aclk, aresetn, v_pipe_reg[5],
        32'(k_g) < SINE_TABLE_SIZE, "table index out of range")

endmodule

// ===== dv/sonar_point_checker.sv =====
// watches both channels of the sonar point converter, predicts each point word and compares
// depends on sptc_pkg for register addresses; config shadow is written by the testbench top
module sonar_point_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [15:0]         s_intensity,
    input  logic [9:0]          s_range_bin,
    input  logic [9:0]          s_azimuth_bin,
    input  logic                s_frame_end,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_point_valid,
    input  logic signed [18:0]  m_point_x,
    input  logic signed [18:0]  m_point_y,
    input  logic                m_frame_last,
    input  logic                cfg_we,
    input  sptc_pkg::reg_addr_t cfg_addr,
    input  logic [31:0]         cfg_data,
    output int                  fail_count,
    output int                  pending_points
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TWO_PI = 64'sd1686629713;
    localparam longint PI_VAL = TWO_PI / 2;
    localparam longint HALF_PI = TWO_PI / 4;
    localparam longint TURN_Q8 = 92160;
    localparam longint TABLE_SIZE = 1024;
    localparam longint BIN_MAX = 1024;
    localparam longint LIMIT = 256000;

    typedef struct packed {
        logic               pv;
        logic signed [18:0] px;
        logic signed [18:0] py;
        logic               last;
    } point_t;

    logic [9:0]  min_rng;
    logic [9:0]  max_rng;
    logic [8:0]  fan_deg;
    logic [15:0] thresh;
    logic [10:0] rbins;
    logic [10:0] abins;
    point_t      point_q[$];

    function automatic longint fdiv(longint n, longint dv);
        longint q;
        q = n / dv;
        if ((n % dv) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint clip_coord(longint v);
        if (v > LIMIT) return LIMIT;
        if (v < -LIMIT) return -LIMIT;
        return v;
    endfunction

    function automatic longint taylor_sine(longint ph);
        longint xx, x2, term, sum;
        logic neg;
        neg = 1'b0;
        xx = ph;
        if (xx >= PI_VAL) begin
            xx -= PI_VAL;
            neg = 1'b1;
        end
        if (xx > HALF_PI) xx = PI_VAL - xx;
        if (xx < 0) xx = 0;
        x2 = (xx * xx) >>> 28;
        term = xx;
        sum = xx;
        for (int n = 1; n <= 5; n++) begin
            term = ((term * x2) >>> 28) / ((2 * n) * (2 * n + 1));
            if (n & 1) sum -= term;
            else sum += term;
        end
        if (sum < 0) sum = 0;
        sum = (sum + 4096) >>> 13;
        if (sum > 32767) sum = 32767;
        return neg ? -sum : sum;
    endfunction

    function automatic longint bin_limit(longint c);
        if (c == 0) return 1;
        if (c > BIN_MAX) return BIN_MAX;
        return c;
    endfunction

    function automatic point_t convert_bin(logic [15:0] inten, logic [9:0] rb_i,
                                           logic [9:0] az_i, logic fe);
        point_t p;
        longint rb, ab, d, a, w, k, phs, phc, s, c;
        p = '0;
        p.last = fe;
        if (inten < thresh) return p;
        rb = bin_limit(rbins);
        ab = bin_limit(abins);
        d = longint'(min_rng) * 256 +
            fdiv(longint'(rb_i) * (longint'(max_rng) - longint'(min_rng)) * 256, rb);
        a = longint'(fan_deg >> 1) * 256 - (longint'(fan_deg) * longint'(az_i) * 256) / ab;
        w = a % TURN_Q8;
        if (w < 0) w += TURN_Q8;
        k = ((w * TABLE_SIZE + TURN_Q8 / 2) / TURN_Q8) % TABLE_SIZE;
        phs = (k * TWO_PI) / TABLE_SIZE;
        phc = phs + HALF_PI;
        if (phc >= TWO_PI) phc -= TWO_PI;
        s = taylor_sine(phs);
        c = taylor_sine(phc);
        p.pv = 1'b1;
        p.px = 19'(clip_coord(fdiv(d * c + 16384, 32768)));
        p.py = 19'(clip_coord(-fdiv(d * s + 16384, 32768)));
        return p;
    endfunction

    always @(posedge aclk) begin
        point_t exp_p;
        if (!aresetn) begin
            min_rng <= 10'd0;
            max_rng <= 10'd100;
            fan_deg <= 9'd120;
            thresh <= 16'd32768;
            rbins <= 11'd512;
            abins <= 11'd256;
            point_q.delete();
            fail_count <= 0;
            pending_points <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    sptc_pkg::REG_MIN_RANGE: min_rng <= cfg_data[9:0];
                    sptc_pkg::REG_MAX_RANGE: max_rng <= cfg_data[9:0];
                    sptc_pkg::REG_FAN_WIDTH: fan_deg <= cfg_data[8:0];
                    sptc_pkg::REG_THRESHOLD: thresh <= cfg_data[15:0];
                    sptc_pkg::REG_RANGE_BINS: rbins <= cfg_data[10:0];
                    sptc_pkg::REG_AZ_BINS: abins <= cfg_data[10:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                point_q.insert(point_q.size(), convert_bin(s_intensity, s_range_bin,
                                                           s_azimuth_bin, s_frame_end));
            if (m_valid && m_ready) begin
                if (point_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected point word");
                    fail_count <= fail_count + 1;
                end else begin
                    exp_p = point_q.pop_front();
                    if (exp_p.pv !== m_point_valid || exp_p.px !== m_point_x ||
                        exp_p.py !== m_point_y || exp_p.last !== m_frame_last) begin
                        if (fail_count < 10)
                            $display("exp v=%0d x=%0d y=%0d l=%0d, got v=%0d x=%0d y=%0d l=%0d",
                                     exp_p.pv, exp_p.px, exp_p.py, exp_p.last,
                                     m_point_valid, m_point_x, m_point_y, m_frame_last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_points <= point_q.size();
        end
    end
endmodule

// ===== dv/sonar_polar_to_cartesian_points_tb.sv =====
// stimulus and verdict for the sonar point converter: apb setup phases, directed and random bins
// depends on sptc_pkg, sonar_point_checker and the block itself
module sonar_polar_to_cartesian_points_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk;
    logic               aresetn;
    logic               psel, penable, pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid, s_ready;
    logic [15:0]        s_intensity;
    logic [9:0]         s_range_bin, s_azimuth_bin;
    logic               s_frame_end;
    logic               m_valid, m_ready;
    logic               m_point_valid, m_frame_last;
    logic signed [18:0] m_point_x, m_point_y;
    int                 fail_count, pending_points;
    logic               calm;

    sonar_polar_to_cartesian_points dut (.*);

    sonar_point_checker checker_i (
        .aclk, .aresetn, .s_valid, .s_ready, .s_intensity, .s_range_bin, .s_azimuth_bin,
        .s_frame_end, .m_valid, .m_ready, .m_point_valid, .m_point_x, .m_point_y,
        .m_frame_last,
        .cfg_we(psel && penable && pwrite && pready),
        .cfg_addr(sptc_pkg::reg_addr_t'(paddr[4:2])), .cfg_data(pwdata),
        .fail_count, .pending_points
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // receiver stalls in bursts
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 3);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic write_reg(sptc_pkg::reg_addr_t a, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {a, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_points();
        while (pending_points != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    task automatic send_bin(logic [15:0] it, logic [9:0] r, logic [9:0] az, logic fe);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_intensity <= it;
        s_range_bin <= r;
        s_azimuth_bin <= az;
        s_frame_end <= fe;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic setup(int mn, int mx, int fan, int th, int rb, int ab);
        drain_points();
        write_reg(sptc_pkg::REG_MIN_RANGE, mn);
        write_reg(sptc_pkg::REG_MAX_RANGE, mx);
        write_reg(sptc_pkg::REG_FAN_WIDTH, fan);
        write_reg(sptc_pkg::REG_THRESHOLD, th);
        write_reg(sptc_pkg::REG_RANGE_BINS, rb);
        write_reg(sptc_pkg::REG_AZ_BINS, ab);
    endtask

    task automatic random_bins(int n, int rb, int ab);
        logic [9:0] r, az;
        for (int i = 0; i < n; i++) begin
            r = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, rb - 1));
            az = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, ab - 1));
            send_bin(16'($urandom), r, az, $urandom_range(0, 15) == 0);
        end
        idle_sender();
    endtask

    initial begin
        int rb, ab;
        aresetn = 1'b0;
        calm = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_intensity = '0; s_range_bin = '0; s_azimuth_bin = '0;
        s_frame_end = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed bins at reset settings
        send_bin(16'hFFFF, 10'd0, 10'd0, 1'b0);
        send_bin(16'h8000, 10'd511, 10'd255, 1'b1);
        send_bin(16'h7FFF, 10'd100, 10'd100, 1'b1);
        send_bin(16'h0000, 10'h3FF, 10'h3FF, 1'b0);
        send_bin(16'hFFFF, 10'h3FF, 10'h3FF, 1'b1);
        send_bin(16'hFFFF, 10'd256, 10'd128, 1'b0);
        idle_sender();
        // max below min, zero counts, full fan, zero threshold
        setup(1000, 0, 360, 0, 0, 0);
        send_bin(16'h0000, 10'd0, 10'd0, 1'b0);
        send_bin(16'h0001, 10'd1, 10'd1, 1'b1);
        send_bin(16'hFFFF, 10'h3FF, 10'h3FF, 1'b0);
        send_bin(16'h5555, 10'h2AA, 10'h155, 1'b1);
        idle_sender();
        // counts above the maximum, largest ranges, smallest fan
        setup(0, 1000, 1, 65535, 2047, 2047);
        send_bin(16'hFFFF, 10'h3FF, 10'd0, 1'b1);
        send_bin(16'hFFFE, 10'h3FF, 10'h3FF, 1'b0);
        send_bin(16'hFFFF, 10'd512, 10'h3FF, 1'b0);
        idle_sender();
        setup(1023, 1023, 511, 1, 1, 1024);
        send_bin(16'hFFFF, 10'h3FF, 10'h3FF, 1'b1);
        send_bin(16'h0001, 10'd0, 10'd512, 1'b0);
        idle_sender();
        // sender holds off until every point is back
        drain_points();

        for (int ph = 0; ph < 9; ph++) begin
            rb = $urandom_range(1, 1024);
            ab = $urandom_range(1, 1024);
            setup($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(1, 511),
                  $urandom, rb, ab);
            if (ph == 8) calm = 1'b1;
            random_bins(210, rb, ab);
        end

        drain_points();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
